>>> sv/plwm_pkg.sv
// Shared types, constants and helpers for the pattern line and word matcher.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package plwm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int PAT_W       = MAX_PATTERN * 8;
   localparam int PAT_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int LEN_REG_W   = 6;
   localparam int CNT_W       = 16;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int REG_BYTES_W = 4 * CSR_DATA_W;

   localparam logic [CSR_IDX_W-1:0] REG_PAT_LO  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_MID = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_UP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_TOP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_LEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MODE    = 3'd5;

   localparam logic MODE_LINE = 1'b0;
   localparam logic MODE_WORD = 1'b1;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic             matched;
      logic [CNT_W-1:0] record_length;
   } rsp_type;

   typedef struct packed {
      logic [PAT_W-1:0] pattern;
      logic [LEN_W-1:0] length;
      logic             mode;
   } cfg_type;

   function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pattern,
                                           input logic [PAT_IDX_W-1:0] idx);
      pat_byte = pattern[idx*8 +: 8];
   endfunction

endpackage

`default_nettype wire

>>> sv/pattern_line_and_word_matcher_top.sv
// Top level of the pattern line and word matcher: input register, result register.
// Depends on plwm_pkg, plwm_csr and plwm_core.
//
//   channel  | ports                         | direction | moves
//   req      | req_valid req_ready req_item  | in        | one text byte item
//   rsp      | rsp_valid rsp_ready rsp_item  | out       | one record verdict item
//   csr      | csr_we csr_index csr_wdata    | in        | register write, no wait
//
// One item per cycle unless a result stalls; a result moves from input to result register.
// The per-cycle limit is the 32-byte window compare between those two registers.
// Reset is synchronous and leaves the search running with an empty record; no clearing pass.
// A stalled result holds the pipe; the input register still fills while the result waits.
`default_nettype none

module pattern_line_and_word_matcher_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire plwm_pkg::req_type                  req_item,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output plwm_pkg::rsp_type                       rsp_item,
   input  wire logic                               csr_we,
   input  wire logic [plwm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [plwm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   plwm_pkg::cfg_type cfg;
   plwm_pkg::req_type in_item_ff;
   plwm_pkg::rsp_type out_item_ff, res;
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance, res_valid, req_take;

   plwm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   plwm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      if (advance) begin
         out_valid_in = res_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

`default_nettype wire

>>> sv/plwm_csr.sv
// Configuration registers: pattern bytes, pattern length and match mode.
// Depends on plwm_pkg.
`default_nettype none

module plwm_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [plwm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [plwm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output plwm_pkg::cfg_type                       cfg
);

   logic [plwm_pkg::CSR_DATA_W-1:0] pat_lo_ff, pat_mid_ff, pat_up_ff, pat_top_ff;
   logic [plwm_pkg::LEN_REG_W-1:0]  pat_len_ff;
   logic                            mode_ff;
   logic [plwm_pkg::REG_BYTES_W-1:0] pat_all;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff  <= '0;
         pat_mid_ff <= '0;
         pat_up_ff  <= '0;
         pat_top_ff <= '0;
         pat_len_ff <= '0;
         mode_ff    <= plwm_pkg::MODE_LINE;
      end else if (csr_we) begin
         case (csr_index)
            plwm_pkg::REG_PAT_LO:  pat_lo_ff  <= csr_wdata;
            plwm_pkg::REG_PAT_MID: pat_mid_ff <= csr_wdata;
            plwm_pkg::REG_PAT_UP:  pat_up_ff  <= csr_wdata;
            plwm_pkg::REG_PAT_TOP: pat_top_ff <= csr_wdata;
            plwm_pkg::REG_PAT_LEN: pat_len_ff <= csr_wdata[plwm_pkg::LEN_REG_W-1:0];
            plwm_pkg::REG_MODE:    mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign pat_all = {pat_top_ff, pat_up_ff, pat_mid_ff, pat_lo_ff};

   always_comb begin
      cfg.pattern = plwm_pkg::PAT_W'(pat_all);
      if (32'(pat_len_ff) > plwm_pkg::MAX_PATTERN) begin
         cfg.length = plwm_pkg::LEN_W'(plwm_pkg::MAX_PATTERN);
      end else begin
         cfg.length = plwm_pkg::LEN_W'(pat_len_ff);
      end
      cfg.mode = mode_ff;
   end

endmodule

`default_nettype wire

>>> sv/plwm_core.sv
// Record state, sliding window compare and verdict for one registered item.
// Depends on plwm_pkg; driven by the top level's input register.
`default_nettype none

module plwm_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire plwm_pkg::req_type item,
   input  wire plwm_pkg::cfg_type cfg,
   output logic                   res_valid,
   output plwm_pkg::rsp_type      res
);

   logic [7:0] recent_ff [plwm_pkg::MAX_PATTERN];
   logic [7:0] recent_in [plwm_pkg::MAX_PATTERN];
   logic [plwm_pkg::CNT_W-1:0] bytes_ff, bytes_in, bytes_inc;
   logic mbl_ff, mbl_in;
   logic mal_ff, mal_in;
   logic ret_ff, ret_in;
   logic [plwm_pkg::LEN_W-1:0] pos_ff, pos_in;
   logic stopped_ff, stopped_in;

   logic [7:0] b;
   logic       line_mode, is_delim, is_gap, take, all_eq, ok;
   logic [plwm_pkg::LEN_W-1:0]   idx_full;
   logic [plwm_pkg::CNT_W-1:0]   rlen;
   logic [plwm_pkg::CNT_W:0]     len_ext;

   assign b         = item.text_byte;
   assign line_mode = (cfg.mode == plwm_pkg::MODE_LINE);
   assign is_delim  = item.stream_end || b == plwm_pkg::CHAR_LF ||
                      (!line_mode && b == plwm_pkg::CHAR_CR);
   assign is_gap    = !line_mode && (b == plwm_pkg::CHAR_SPACE || b == plwm_pkg::CHAR_TAB);
   assign take      = !stopped_ff && !is_delim && !is_gap;
   assign bytes_inc = (bytes_ff == '1) ? bytes_ff : bytes_ff + 1'b1;
   assign len_ext   = (plwm_pkg::CNT_W+1)'(cfg.length);

   always_comb begin
      recent_in[0] = b;
      for (int j = 1; j < plwm_pkg::MAX_PATTERN; j++) begin
         recent_in[j] = recent_ff[j-1];
      end
   end

   always_comb begin
      all_eq   = 1'b1;
      idx_full = '0;
      for (int j = 0; j < plwm_pkg::MAX_PATTERN; j++) begin
         idx_full = cfg.length - plwm_pkg::LEN_W'(j) - 1'b1;
         if (plwm_pkg::LEN_W'(j) < cfg.length &&
             recent_in[j] != plwm_pkg::pat_byte(cfg.pattern,
                                                idx_full[plwm_pkg::PAT_IDX_W-1:0])) begin
            all_eq = 1'b0;
         end
      end
   end

   always_comb begin
      if (line_mode) begin
         rlen = bytes_ff - plwm_pkg::CNT_W'(ret_ff);
         if (cfg.length == '0) begin
            ok = 1'b1;
         end else if (ret_ff) begin
            ok = mbl_ff;
         end else begin
            ok = mbl_ff || mal_ff;
         end
      end else begin
         rlen = bytes_ff;
         ok = ({1'b0, bytes_ff} == len_ext || {1'b0, bytes_ff} == len_ext + 1'b1) &&
              pos_ff >= cfg.length;
      end
   end

   always_comb begin
      res_valid = 1'b0;
      res.matched = ok;
      res.record_length = rlen;
      bytes_in   = bytes_ff;
      mbl_in     = mbl_ff;
      mal_in     = mal_ff;
      ret_in     = ret_ff;
      pos_in     = pos_ff;
      stopped_in = stopped_ff;
      if (!stopped_ff) begin
         if (is_delim || is_gap) begin
            if (item.stream_end) begin
               stopped_in = 1'b1;
            end
            if (is_delim && bytes_ff == '0) begin
               stopped_in = 1'b1;
            end else begin
               res_valid = 1'b1;
            end
            bytes_in = '0;
            mbl_in   = 1'b0;
            mal_in   = 1'b0;
            ret_in   = 1'b0;
            pos_in   = '0;
         end else begin
            bytes_in = bytes_inc;
            mbl_in   = mbl_ff || mal_ff;
            mal_in   = all_eq && (32'(bytes_inc) >= 32'(cfg.length));
            ret_in   = (b == plwm_pkg::CHAR_CR);
            if (pos_ff < cfg.length &&
                b == plwm_pkg::pat_byte(cfg.pattern, pos_ff[plwm_pkg::PAT_IDX_W-1:0])) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff   <= '0;
         mbl_ff     <= 1'b0;
         mal_ff     <= 1'b0;
         ret_ff     <= 1'b0;
         pos_ff     <= '0;
         stopped_ff <= 1'b0;
      end else if (step) begin
         bytes_ff   <= bytes_in;
         mbl_ff     <= mbl_in;
         mal_ff     <= mal_in;
         ret_ff     <= ret_in;
         pos_ff     <= pos_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < plwm_pkg::MAX_PATTERN; j++) begin
            recent_ff[j] <= '0;
         end
      end else if (step && take) begin
         recent_ff <= recent_in;
      end
   end

`ifndef SYNTHESIS
   a_no_result_when_stopped: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !res_valid)
      else $error("result raised after search stopped");
   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("search stop cleared without reset");
   a_empty_record_clean: assert property (@(posedge clock) disable iff (reset)
      bytes_ff == '0 |-> !mbl_ff && !mal_ff && !ret_ff && pos_ff == '0)
      else $error("empty record carries match state");
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) <= plwm_pkg::MAX_PATTERN)
      else $error("pattern position past pattern end");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for pattern_line_and_word_matcher_top: streams text items,
// writes the pattern registers between phases and checks every record verdict.
// Depends on plwm_pkg and the matcher RTL.
module tb_top;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_LINE   = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int ALPHA_SMALL = 0;
   localparam int ALPHA_FULL  = 1;
   localparam int ALPHA_ONES  = 2;
   localparam logic [7:0] FILL_BYTE = 8'h78;
   localparam logic [7:0] SAFE_BYTE = 8'h5F;

   class verdict_scoreboard;
      plwm_pkg::rsp_type pending_verdicts[$];
      int errors;
      logic [plwm_pkg::CSR_DATA_W-1:0] pat_regs[4];
      logic [plwm_pkg::LEN_REG_W-1:0] pat_len;
      logic mode;
      logic [7:0] window[plwm_pkg::MAX_PATTERN];
      logic [plwm_pkg::CNT_W-1:0] rec_bytes;
      logic hit_earlier, hit_last, ends_in_return, stopped;
      logic [plwm_pkg::LEN_REG_W-1:0] subseq_pos;

      function new();
         errors = 0;
         foreach (pat_regs[i]) pat_regs[i] = '0;
         foreach (window[i]) window[i] = 8'h00;
         pat_len = '0;
         mode = plwm_pkg::MODE_LINE;
         stopped = 1'b0;
         clear_record();
      endfunction

      function void clear_record();
         rec_bytes = '0;
         hit_earlier = 1'b0;
         hit_last = 1'b0;
         ends_in_return = 1'b0;
         subseq_pos = '0;
      endfunction

      function int eff_len();
         return (pat_len > plwm_pkg::MAX_PATTERN) ? plwm_pkg::MAX_PATTERN : int'(pat_len);
      endfunction

      function logic [7:0] pattern_byte(int k);
         if (k >= plwm_pkg::MAX_PATTERN) return 8'h00;
         return pat_regs[k / 8][(k % 8) * 8 +: 8];
      endfunction

      function void set_reg(logic [plwm_pkg::CSR_IDX_W-1:0] idx,
                            logic [plwm_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            plwm_pkg::REG_PAT_LO, plwm_pkg::REG_PAT_MID,
            plwm_pkg::REG_PAT_UP, plwm_pkg::REG_PAT_TOP: pat_regs[idx[1:0]] = value;
            plwm_pkg::REG_PAT_LEN: pat_len = value[plwm_pkg::LEN_REG_W-1:0];
            plwm_pkg::REG_MODE: mode = value[0];
            default: ;
         endcase
      endfunction

      function void close_record(bit line_mode);
         int len;
         int rlen;
         plwm_pkg::rsp_type v;
         len = eff_len();
         if (line_mode) begin
            rlen = int'(rec_bytes) - (ends_in_return ? 1 : 0);
            if (len == 0) v.matched = 1'b1;
            else if (ends_in_return) v.matched = hit_earlier;
            else v.matched = hit_earlier | hit_last;
         end else begin
            rlen = int'(rec_bytes);
            v.matched = (rlen == len || rlen == len + 1) && int'(subseq_pos) >= len;
         end
         v.record_length = rlen[plwm_pkg::CNT_W-1:0];
         pending_verdicts.push_back(v);
         clear_record();
      endfunction

      function void note_byte(plwm_pkg::req_type it);
         logic [7:0] b;
         bit line_mode;
         int len;
         bit hit;
         b = it.text_byte;
         line_mode = (mode == plwm_pkg::MODE_LINE);
         len = eff_len();
         if (stopped) return;
         if (it.stream_end || b == plwm_pkg::CHAR_LF ||
             (!line_mode && b == plwm_pkg::CHAR_CR)) begin
            if (it.stream_end) stopped = 1'b1;
            if (rec_bytes == '0) begin
               stopped = 1'b1;
               clear_record();
            end else begin
               close_record(line_mode);
            end
            return;
         end
         if (!line_mode && (b == plwm_pkg::CHAR_SPACE || b == plwm_pkg::CHAR_TAB)) begin
            close_record(1'b0);
            return;
         end
         for (int k = plwm_pkg::MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = b;
         if (rec_bytes != '1) rec_bytes++;
         hit_earlier = hit_earlier | hit_last;
         hit = (int'(rec_bytes) >= len);
         for (int k = 0; k < len; k++)
            if (window[len-1-k] != pattern_byte(k)) hit = 1'b0;
         hit_last = hit;
         ends_in_return = (b == plwm_pkg::CHAR_CR);
         if (int'(subseq_pos) < len && b == pattern_byte(int'(subseq_pos))) subseq_pos++;
      endfunction

      function void check_verdict(plwm_pkg::rsp_type got);
         plwm_pkg::rsp_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual matched %0d length %0d",
                     $time, got.matched, got.record_length);
            errors++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.matched !== want.matched) begin
            $display("%0t: matched mismatch, expected %0d, actual %0d",
                     $time, want.matched, got.matched);
            errors++;
         end
         if (got.record_length !== want.record_length) begin
            $display("%0t: record_length mismatch, expected %0d, actual %0d",
                     $time, want.record_length, got.record_length);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   plwm_pkg::req_type req_item = '0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   plwm_pkg::rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [plwm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [plwm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   verdict_scoreboard sb = new();
   logic [7:0] pat_text[plwm_pkg::MAX_PATTERN];
   logic [7:0] text_q[$];
   int pat_len_cur = 0;
   int alpha_kind = ALPHA_SMALL;
   int sent_count = 0;
   int cycle_count = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;

   pattern_line_and_word_matcher_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : rsp_side
      int stall;
      int hold_left;
      stall = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_verdict(rsp_item);
            stall = idle_on ? $urandom_range(0, 8) : 0;
         end
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] content_byte(input bit word_mode);
      logic [7:0] b;
      if (alpha_kind == ALPHA_SMALL) b = 8'($urandom_range(8'h61, 8'h64));
      else b = 8'($urandom_range(0, 255));
      if (b == plwm_pkg::CHAR_LF ||
          (word_mode && (b == plwm_pkg::CHAR_CR || b == plwm_pkg::CHAR_SPACE ||
                         b == plwm_pkg::CHAR_TAB)))
         b = SAFE_BYTE;
      return b;
   endfunction

   task automatic send_text(input logic [7:0] raw, input logic end_flag);
      plwm_pkg::req_type it;
      int gap;
      it.text_byte = raw;
      it.stream_end = end_flag;
      // keep the search alive: never close an empty record before the end
      if (!end_flag && !sb.stopped && sb.rec_bytes == '0 &&
          (raw == plwm_pkg::CHAR_LF ||
           (sb.mode == plwm_pkg::MODE_WORD && raw == plwm_pkg::CHAR_CR)))
         it.text_byte = FILL_BYTE;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(it);
      sent_count++;
   endtask

   task automatic send_queue();
      while (text_q.size() != 0) send_text(text_q.pop_front(), 1'b0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [plwm_pkg::CSR_IDX_W-1:0] idx,
                          input logic [plwm_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic load_settings(input int plen, input logic m);
      logic [plwm_pkg::CSR_DATA_W-1:0] regs[4];
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 8; j++) regs[i][8*j +: 8] = pat_text[8*i + j];
      pat_len_cur = plen;
      put_reg(plwm_pkg::REG_PAT_LO, regs[0]);
      put_reg(plwm_pkg::REG_PAT_MID, regs[1]);
      put_reg(plwm_pkg::REG_PAT_UP, regs[2]);
      put_reg(plwm_pkg::REG_PAT_TOP, regs[3]);
      put_reg(plwm_pkg::REG_PAT_LEN, plwm_pkg::CSR_DATA_W'(plen));
      put_reg(plwm_pkg::REG_MODE, plwm_pkg::CSR_DATA_W'(m));
      csr_we <= 1'b0;
   endtask

   task automatic build_record(input bit word_mode);
      int eff;
      int kind;
      int pos;
      logic [7:0] extra;
      logic [7:0] delim;
      eff = (pat_len_cur > plwm_pkg::MAX_PATTERN) ? plwm_pkg::MAX_PATTERN : pat_len_cur;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom));
         return;
      end
      kind = $urandom_range(0, 3);
      if (!word_mode) begin
         repeat ($urandom_range(0, 6)) text_q.push_back(content_byte(1'b0));
         pos = (kind == 1) ? $urandom_range(0, eff) : eff;
         if (kind != 0)
            for (int k = 0; k < pos; k++) text_q.push_back(pat_text[k]);
         repeat ($urandom_range(0, 6)) text_q.push_back(content_byte(1'b0));
         if ($urandom_range(0, 3) == 0) text_q.push_back(plwm_pkg::CHAR_CR);
         text_q.push_back(plwm_pkg::CHAR_LF);
      end else begin
         pos = $urandom_range(0, eff);
         extra = content_byte(1'b1);
         if (kind == 3) begin
            repeat (eff + $urandom_range(0, 2)) text_q.push_back(content_byte(1'b1));
         end else begin
            for (int k = 0; k <= eff; k++) begin
               if (kind == 1 && k == pos) text_q.push_back(extra);
               if (k < eff && !(kind == 2 && k == pos)) text_q.push_back(pat_text[k]);
            end
         end
         case ($urandom_range(0, 3))
            0: delim = plwm_pkg::CHAR_SPACE;
            1: delim = plwm_pkg::CHAR_TAB;
            2: delim = plwm_pkg::CHAR_CR;
            default: delim = plwm_pkg::CHAR_LF;
         endcase
         text_q.push_back(delim);
      end
   endtask

   task automatic run_phase(input logic m, input int plen, input int alpha,
                            input int n_items, input bit idle);
      int first;
      idle_on = idle;
      alpha_kind = alpha;
      for (int k = 0; k < plwm_pkg::MAX_PATTERN; k++)
         pat_text[k] = (alpha == ALPHA_SMALL) ? 8'($urandom_range(8'h61, 8'h64)) :
                       (alpha == ALPHA_ONES) ? 8'hFF : 8'($urandom_range(0, 255));
      load_settings(plen, m);
      first = sent_count;
      while (sent_count - first < n_items) begin
         build_record(m == plwm_pkg::MODE_WORD);
         send_queue();
      end
      settle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (pat_text[k]) pat_text[k] = 8'h00;
      pat_text[0] = 8'h62;
      pat_text[1] = plwm_pkg::CHAR_CR;
      load_settings(2, plwm_pkg::MODE_LINE);
      text_q = {8'h61, 8'h62, plwm_pkg::CHAR_CR, plwm_pkg::CHAR_LF, 8'h62,
                plwm_pkg::CHAR_CR, 8'h78, plwm_pkg::CHAR_LF, 8'hFF, 8'h00,
                plwm_pkg::CHAR_LF};
      send_queue();
      settle();
      pat_text[0] = 8'h61;
      pat_text[1] = 8'h62;
      load_settings(2, plwm_pkg::MODE_WORD);
      text_q = {plwm_pkg::CHAR_SPACE, 8'h61, 8'h78, 8'h62, plwm_pkg::CHAR_TAB, 8'h61,
                8'h62, plwm_pkg::CHAR_CR, 8'h61, plwm_pkg::CHAR_LF};
      send_queue();
      settle();

      run_phase(plwm_pkg::MODE_LINE, $urandom_range(1, 6), ALPHA_SMALL, 300, 1'b1);
      hold_request = 1'b1;
      run_phase(plwm_pkg::MODE_WORD, $urandom_range(1, 5), ALPHA_SMALL, 300, 1'b1);
      run_phase(plwm_pkg::MODE_LINE, 0, ALPHA_FULL, 100, 1'b1);
      run_phase(plwm_pkg::MODE_WORD, 0, ALPHA_SMALL, 100, 1'b1);
      run_phase(plwm_pkg::MODE_LINE, plwm_pkg::MAX_PATTERN, ALPHA_FULL, 250, 1'b0);
      run_phase(plwm_pkg::MODE_WORD, 63, ALPHA_FULL, 250, 1'b1);
      run_phase(plwm_pkg::MODE_LINE, plwm_pkg::MAX_PATTERN + 1, ALPHA_ONES, 150, 1'b1);
      run_phase(plwm_pkg::MODE_WORD, 1, ALPHA_SMALL, 200, 1'b1);
      run_phase(plwm_pkg::MODE_LINE, $urandom_range(1, plwm_pkg::MAX_PATTERN),
                ALPHA_FULL, 200, 1'b0);

      // one long line ended by a stripped return
      run_phase(plwm_pkg::MODE_LINE, 3, ALPHA_SMALL, 0, 1'b0);
      repeat (LONG_LINE) text_q.push_back(content_byte(1'b0));
      text_q.push_back(plwm_pkg::CHAR_CR);
      text_q.push_back(plwm_pkg::CHAR_LF);
      send_queue();
      settle();

      idle_on = 1'b1;
      text_q = {8'h61, 8'h62};
      send_queue();
      send_text(8'($urandom), 1'b1);
      send_text(plwm_pkg::CHAR_LF, 1'b0);
      send_text(8'h61, 1'b0);
      send_text(8'($urandom), 1'b1);
      settle();
      repeat (6) @(posedge clock);

      if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
